// ===== hw/rtl/tfs_pkg.sv =====
// types and constants shared by the timed fill sequencer modules
`default_nettype none

package tfs_pkg;

  localparam int unsigned StageWidth = 15;
  localparam int unsigned CoolWidth  = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned SumWidth   = 18;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LOWERING  = 3'd0,
    CFG_PURGING   = 3'd1,
    CFG_FILLING   = 3'd2,
    CFG_CYCLE_CD  = 3'd3,
    CFG_ESTOP_CD  = 3'd4
  } cfg_idx_e;

  localparam logic [StageWidth-1:0] LoweringReset = 15'd1000;
  localparam logic [StageWidth-1:0] PurgingReset  = 15'd2000;
  localparam logic [StageWidth-1:0] FillingReset  = 15'd5000;
  localparam logic [CoolWidth-1:0]  CycleCdReset  = 16'd2000;
  localparam logic [CoolWidth-1:0]  EstopCdReset  = 16'd3000;

  typedef struct packed {
    logic [StageWidth-1:0] lowering;
    logic [StageWidth-1:0] purging;
    logic [StageWidth-1:0] filling;
    logic [CoolWidth-1:0]  cycle_cd;
    logic [CoolWidth-1:0]  estop_cd;
  } cfg_t;

  typedef struct packed {
    logic in_cycle;
    logic lowered;
    logic purged;
    logic filled;
    logic raised;
    logic lockout;
    logic cylinder;
    logic purge;
    logic fill;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfs_step.sv =====
// next-state logic of the sequencer for one tick or button transfer
`default_nettype none

module tfs_step #(
  parameter int unsigned TimerBits = 18
) (
  input  wire                  cmd_i,
  input  wire                  held_down_i,
  input  wire tfs_pkg::cfg_t   cfg_i,
  input  wire tfs_pkg::flags_t flags_i,
  input  wire [TimerBits-1:0]  elapsed_i,
  output tfs_pkg::flags_t      flags_o,
  output logic [TimerBits-1:0] elapsed_o
);

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  logic [tfs_pkg::SumWidth-1:0] s1, s2, s3, s4;
  logic [TimerBits-1:0] t1, t2, t3, t4, estop_lim;

  always_comb begin
    s1 = tfs_pkg::SumWidth'(cfg_i.lowering);
    s2 = s1 + tfs_pkg::SumWidth'(cfg_i.purging);
    s3 = s2 + tfs_pkg::SumWidth'(cfg_i.filling);
    s4 = s3 + tfs_pkg::SumWidth'(cfg_i.cycle_cd);
    t1 = TimerBits'(s1);
    t2 = TimerBits'(s2);
    t3 = TimerBits'(s3);
    t4 = TimerBits'(s4);
    estop_lim = TimerBits'(cfg_i.estop_cd);
  end

  always_comb begin
    flags_o   = flags_i;
    elapsed_o = elapsed_i;
    if (cmd_i) begin
      if (!flags_i.lockout && held_down_i) begin
        if (flags_i.in_cycle) begin
          // emergency stop
          flags_o.purge    = 1'b0;
          flags_o.purged   = 1'b0;
          flags_o.fill     = 1'b0;
          flags_o.filled   = 1'b0;
          flags_o.cylinder = 1'b0;
          flags_o.raised   = 1'b1;
          flags_o.in_cycle = 1'b0;
          flags_o.lockout  = 1'b1;
          elapsed_o        = '0;
        end else begin
          flags_o.in_cycle = 1'b1;
          flags_o.lowered  = 1'b1;
          flags_o.cylinder = 1'b1;
          elapsed_o        = '0;
        end
      end
    end else begin
      if (elapsed_i != TimerMax) begin
        elapsed_o = elapsed_i + TimerBits'(1);
      end
      if (flags_i.lockout && (elapsed_o > estop_lim)) begin
        flags_o.in_cycle = 1'b0;
        flags_o.lowered  = 1'b0;
        flags_o.purged   = 1'b0;
        flags_o.filled   = 1'b0;
        flags_o.raised   = 1'b0;
        flags_o.lockout  = 1'b0;
      end
      if (flags_o.in_cycle) begin
        if (elapsed_o > t4) begin
          flags_o.in_cycle = 1'b0;
          flags_o.lowered  = 1'b0;
          flags_o.purged   = 1'b0;
          flags_o.filled   = 1'b0;
          flags_o.raised   = 1'b0;
          flags_o.lockout  = 1'b0;
        end else if (elapsed_o > t3) begin
          if (flags_o.filled && !flags_o.raised) begin
            flags_o.fill     = 1'b0;
            flags_o.filled   = 1'b0;
            flags_o.raised   = 1'b1;
            flags_o.cylinder = 1'b0;
          end
        end else if (elapsed_o > t2) begin
          if (flags_o.purged && !flags_o.filled) begin
            flags_o.purge  = 1'b0;
            flags_o.purged = 1'b0;
            flags_o.filled = 1'b1;
            flags_o.fill   = 1'b1;
          end
        end else if (elapsed_o > t1) begin
          if (flags_o.lowered && !flags_o.purged) begin
            flags_o.purged = 1'b1;
            flags_o.purge  = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/timed_fill_sequencer_core.sv =====
// top level of the timed fill sequencer: config registers, state and result register
`default_nettype none

// Bottle filler sequencer driven by millisecond ticks (cmd 0) and button
// events (cmd 1). Each accepted transfer updates the sequencer state in the
// same clock and yields one result, the output levels after that transfer,
// from a result register. One transfer is taken every cycle; the input is held
// only while the result register is full and not taken. Stage times must be
// written via the config port only while idle; the block does not check this.

module timed_fill_sequencer_core #(
  parameter int unsigned TIMER_BITS = 18
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [tfs_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire [tfs_pkg::CfgWidth-1:0]    cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            cmd_i,
  input  wire                            held_down_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           cylinder_down_o,
  output logic                           purge_on_o,
  output logic                           fill_on_o,
  output logic                           busy_res_o,
  output logic                           estop_lockout_o
);

  tfs_pkg::cfg_t   cfg_q;
  tfs_pkg::flags_t flags_q, flags_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lowering <= tfs_pkg::LoweringReset;
      cfg_q.purging  <= tfs_pkg::PurgingReset;
      cfg_q.filling  <= tfs_pkg::FillingReset;
      cfg_q.cycle_cd <= tfs_pkg::CycleCdReset;
      cfg_q.estop_cd <= tfs_pkg::EstopCdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfs_pkg::CFG_LOWERING: cfg_q.lowering <= cfg_data_i[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_PURGING:  cfg_q.purging  <= cfg_data_i[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_FILLING:  cfg_q.filling  <= cfg_data_i[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_CYCLE_CD: cfg_q.cycle_cd <= cfg_data_i;
        tfs_pkg::CFG_ESTOP_CD: cfg_q.estop_cd <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tfs_step #(
    .TimerBits(TIMER_BITS)
  ) u_step (
    .cmd_i      (cmd_i),
    .held_down_i(held_down_i),
    .cfg_i      (cfg_q),
    .flags_i    (flags_q),
    .elapsed_i  (elapsed_q),
    .flags_o    (flags_d),
    .elapsed_o  (elapsed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        flags_q   <= flags_d;
        elapsed_q <= elapsed_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cylinder_down_o <= flags_d.cylinder;
      purge_on_o      <= flags_d.purge;
      fill_on_o       <= flags_d.fill;
      busy_res_o      <= flags_d.in_cycle;
      estop_lockout_o <= flags_d.lockout;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== bench/tb_timed_fill_sequencer_core.sv =====
// testbench for timed_fill_sequencer_core: predicted output levels checked per transfer
`timescale 1ns / 100ps

module tb_timed_fill_sequencer_core;

  localparam int unsigned TimerBits = 18;
  localparam logic CmdTick = 1'b0;
  localparam logic CmdButton = 1'b1;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 270;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic cylinder;
    logic purge;
    logic fill;
    logic busy;
    logic lockout;
  } levels_t;

  class filler_scoreboard;
    tfs_pkg::cfg_t cfg;
    tfs_pkg::flags_t st;
    logic [TimerBits-1:0] elapsed;
    levels_t want_levels[$];
    int unsigned fails;

    function new();
      cfg = '{lowering: tfs_pkg::LoweringReset, purging: tfs_pkg::PurgingReset,
              filling: tfs_pkg::FillingReset, cycle_cd: tfs_pkg::CycleCdReset,
              estop_cd: tfs_pkg::EstopCdReset};
      st = '0;
      elapsed = '0;
      fails = 0;
    endfunction

    function void write_reg(logic [tfs_pkg::CfgIdxWidth-1:0] idx,
                            logic [tfs_pkg::CfgWidth-1:0] data);
      case (idx)
        tfs_pkg::CFG_LOWERING: cfg.lowering = data[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_PURGING:  cfg.purging = data[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_FILLING:  cfg.filling = data[tfs_pkg::StageWidth-1:0];
        tfs_pkg::CFG_CYCLE_CD: cfg.cycle_cd = data[tfs_pkg::CoolWidth-1:0];
        tfs_pkg::CFG_ESTOP_CD: cfg.estop_cd = data[tfs_pkg::CoolWidth-1:0];
        default: ;
      endcase
    endfunction

    function void end_cycle();
      st.in_cycle = 1'b0;
      st.lowered = 1'b0;
      st.purged = 1'b0;
      st.filled = 1'b0;
      st.raised = 1'b0;
      st.lockout = 1'b0;
    endfunction

    function void run_stages();
      logic [tfs_pkg::SumWidth-1:0] s1, s2, s3, s4;
      s1 = tfs_pkg::SumWidth'(cfg.lowering);
      s2 = s1 + tfs_pkg::SumWidth'(cfg.purging);
      s3 = s2 + tfs_pkg::SumWidth'(cfg.filling);
      s4 = s3 + tfs_pkg::SumWidth'(cfg.cycle_cd);
      if (elapsed > s4) begin
        end_cycle();
      end else if (elapsed > s3) begin
        if (st.filled && !st.raised) begin
          st.fill = 1'b0;
          st.filled = 1'b0;
          st.raised = 1'b1;
          st.cylinder = 1'b0;
        end
      end else if (elapsed > s2) begin
        if (st.purged && !st.filled) begin
          st.purge = 1'b0;
          st.purged = 1'b0;
          st.filled = 1'b1;
          st.fill = 1'b1;
        end
      end else if (elapsed > s1) begin
        if (st.lowered && !st.purged) begin
          st.purged = 1'b1;
          st.purge = 1'b1;
        end
      end
    endfunction

    function void note_transfer(logic c, logic held);
      if (c == CmdButton) begin
        if (!st.lockout && held) begin
          if (st.in_cycle) begin
            // emergency stop
            st.purge = 1'b0;
            st.purged = 1'b0;
            st.fill = 1'b0;
            st.filled = 1'b0;
            st.cylinder = 1'b0;
            st.raised = 1'b1;
            st.in_cycle = 1'b0;
            st.lockout = 1'b1;
            elapsed = '0;
          end else begin
            st.in_cycle = 1'b1;
            st.lowered = 1'b1;
            st.cylinder = 1'b1;
            elapsed = '0;
          end
        end
      end else begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (st.lockout && elapsed > cfg.estop_cd) end_cycle();
        if (st.in_cycle) run_stages();
      end
      want_levels.push_back(levels_t'{st.cylinder, st.purge, st.fill, st.in_cycle,
                                      st.lockout});
    endfunction

    function void compare_bit(string name, logic exp_bit, logic got_bit);
      if (exp_bit !== got_bit) begin
        $error("%s mismatch: expected %b, got %b", name, exp_bit, got_bit);
        fails++;
      end
    endfunction

    function void check_levels(levels_t got);
      levels_t exp_lv;
      if (want_levels.size() == 0) begin
        $error("result transfer with nothing pending: %b", got);
        fails++;
        return;
      end
      exp_lv = want_levels.pop_front();
      compare_bit("cylinder_down", exp_lv.cylinder, got.cylinder);
      compare_bit("purge_on", exp_lv.purge, got.purge);
      compare_bit("fill_on", exp_lv.fill, got.fill);
      compare_bit("busy_res", exp_lv.busy, got.busy);
      compare_bit("estop_lockout", exp_lv.lockout, got.lockout);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [tfs_pkg::CfgIdxWidth-1:0] cfg_idx = '0;
  logic [tfs_pkg::CfgWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic cmd = 1'b0;
  logic held_down = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic cylinder_down, purge_on, fill_on, busy_res, estop_lockout;

  logic hold_req = 1'b0;
  int unsigned burst_left = 0;
  filler_scoreboard sb;

  always #5 clk_i = ~clk_i;

  timed_fill_sequencer_core #(
    .TIMER_BITS(TimerBits)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .cmd_i(cmd),
    .held_down_i(held_down),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .cylinder_down_o(cylinder_down),
    .purge_on_o(purge_on),
    .fill_on_o(fill_on),
    .busy_res_o(busy_res),
    .estop_lockout_o(estop_lockout)
  );

  // results are checked before the same-edge input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        sb.check_levels({cylinder_down, purge_on, fill_on, busy_res, estop_lockout});
      end
      if (in_valid && in_ready) sb.note_transfer(cmd, held_down);
    end
  end

  initial begin : receiver
    int unsigned stretch, ready_pct;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        stretch = $urandom_range(1, 40);
        ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 90);
        repeat (stretch) begin
          out_ready <= ($urandom_range(1, 100) <= ready_pct);
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_item(logic c, logic h);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    held_down <= h;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.want_levels.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tfs_pkg::CfgIdxWidth-1:0] idx,
                           logic [tfs_pkg::CfgWidth-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(tfs_pkg::cfg_t s);
    write_reg(tfs_pkg::CFG_LOWERING, tfs_pkg::CfgWidth'(s.lowering));
    write_reg(tfs_pkg::CFG_PURGING, tfs_pkg::CfgWidth'(s.purging));
    write_reg(tfs_pkg::CFG_FILLING, tfs_pkg::CfgWidth'(s.filling));
    write_reg(tfs_pkg::CFG_CYCLE_CD, s.cycle_cd);
    write_reg(tfs_pkg::CFG_ESTOP_CD, s.estop_cd);
    // unused indexes must not disturb anything
    for (int i = int'(tfs_pkg::CFG_ESTOP_CD) + 1; i < 2 ** tfs_pkg::CfgIdxWidth; i++) begin
      write_reg(tfs_pkg::CfgIdxWidth'(i), tfs_pkg::CfgWidth'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    tfs_pkg::cfg_t s;
    int unsigned btn_div;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle events under reset timing
    send_item(CmdTick, 1'b1);
    send_item(CmdButton, 1'b0);
    drain();
    apply_settings('{lowering: 15'd1, purging: 15'd1, filling: 15'd1,
                     cycle_cd: 16'd1, estop_cd: 16'd2});
    // full cycle
    send_item(CmdButton, 1'b1);
    repeat (5) send_item(CmdTick, 1'b0);
    // stop while lowered, button during lockout
    send_item(CmdButton, 1'b1);
    send_item(CmdTick, 1'b0);
    send_item(CmdButton, 1'b1);
    send_item(CmdButton, 1'b1);
    repeat (3) send_item(CmdTick, 1'b0);
    // stop during cool-down
    send_item(CmdButton, 1'b1);
    repeat (4) send_item(CmdTick, 1'b0);
    send_item(CmdButton, 1'b1);
    repeat (3) send_item(CmdTick, 1'b0);
    drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) begin
        s = '0;
      end else begin
        s.lowering = tfs_pkg::StageWidth'($urandom_range(0, 6));
        s.purging = tfs_pkg::StageWidth'($urandom_range(0, 6));
        s.filling = tfs_pkg::StageWidth'($urandom_range(0, 6));
        s.cycle_cd = tfs_pkg::CoolWidth'($urandom_range(0, 8));
        s.estop_cd = tfs_pkg::CoolWidth'($urandom_range(0, 8));
      end
      apply_settings(s);
      btn_div = $urandom_range(4, 40);
      if (phase == 1) hold_req = 1'b1;
      repeat (ItemsPerPhase) begin
        send_item(($urandom_range(1, btn_div) == 1) ? CmdButton : CmdTick,
                  1'($urandom_range(0, 3) != 0));
      end
      drain();
    end

    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
